/* design/gcl_pkg.sv */
// shared types and constants of the grand canonical log-sum-exp block
package gcl_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int NEMIT       = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
   localparam int SUM_W       = 33 + $clog2(TABLE_DEPTH);
   localparam int LNK_STEPS   = SUM_W - 33;
   localparam int MEAN_W      = 38 + $clog2(TABLE_DEPTH);
   localparam int MEAN2_W     = 33 + 2 * AW + $clog2(TABLE_DEPTH);

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [36:0] EXP_LIMIT = 37'(33 * 64'd2977044472);
   localparam logic [4:0]  EXP_TERMS = 5'd14;
   localparam logic [4:0]  LN_LAST   = 5'd25;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_EVAL  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [33:0] divisor;
      logic [6:0]  iters;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_ln;
      logic [63:0] operand;
   } math_req_type;

   typedef struct packed {
      logic        done;
      logic [35:0] result;
   } math_rsp_type;

endpackage

/* design/gcl_if.sv */
// request and response channel interfaces
interface gcl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  count_index;
   logic signed [39:0] log_weight;

   modport source (output valid, output op, output count_index, output log_weight,
                   input ready);
   modport sink (input valid, input op, input count_index, input log_weight,
                 output ready);
endinterface

interface gcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  entry_index;
   logic [31:0] occupancy;
   logic signed [39:0] log_xi;
   logic [31:0] mean_count;
   logic [31:0] count_variance;
   logic signed [5:0] highest_valid;
   logic        last;

   modport source (output valid, output entry_index, output occupancy,
                   output log_xi, output mean_count, output count_variance,
                   output highest_valid, output last, input ready);
   modport sink (input valid, input entry_index, input occupancy, input log_xi,
                 input mean_count, input count_variance, input highest_valid,
                 input last, output ready);
endinterface

/* design/grand_canonical_log_sum_exp.sv */
// top level: weight table memory, evaluation sequencer and result register
// write and clear items are handled in the idle state; an evaluate item's run
// time grows with the number of valid entries and is set by the exp and ln
// sequences on the shared bit-serial divider, then the results go out in turn;
// one item at a time; the next is taken once the last result has left
// synchronous reset clears the valid marks, log_fugacity and all control state;
// the weight table is undefined until written
module grand_canonical_log_sum_exp (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic signed [39:0] csr_wr_data,
   gcl_req_if.sink            req_ch,
   gcl_rsp_if.source          rsp_ch
);
   import gcl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_P1_RD, S_P1_ACC, S_P2_RD, S_P2_TERM, S_P2_WAIT, S_LN_ST, S_LN_WAIT,
      S_P3_RD, S_P3_TERM, S_P3_WAIT, S_FIN1, S_FIN2, S_FIN3, S_EMIT_RD, S_EMIT_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic signed [39:0] lf_ff, lf_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [AW-1:0] i_ff, i_in;
   logic          any_ff, any_in;
   logic signed [47:0] m_ff, m_in;
   logic [5:0]    highest_ff, highest_in;
   logic [SUM_W-1:0] s_ff, s_in;
   logic [35:0]   lns_ff, lns_in;
   logic signed [48:0] lxi_ff, lxi_in;
   logic [MEAN_W-1:0]  mean32_ff, mean32_in;
   logic [MEAN2_W-1:0] mean2_ff, mean2_in;
   logic [31:0]   mean27_ff, mean27_in;
   logic [MEAN_W-9:0]  m24_ff, m24_in;
   logic [MEAN2_W-9:0] n2_ff, n2_in;
   logic [2*(MEAN_W-8)-1:0] sq_ff, sq_in;
   logic [31:0]   var_ff, var_in;
   logic signed [39:0] lo_ff, lo_in;

   logic          rv_ff, rv_in;
   logic [4:0]    r_idx_ff, r_idx_in;
   logic [31:0]   r_occ_ff, r_occ_in;
   logic          r_last_ff, r_last_in;

   logic signed [39:0] wmem [TABLE_DEPTH];
   logic [32:0]   pmem [TABLE_DEPTH];
   logic signed [39:0] w_rd_ff;
   logic [32:0]   p_rd_ff;
   logic          w_we;
   logic [AW-1:0] w_addr;
   logic          p_we;

   logic signed [47:0] term;
   logic [47:0]   diff;
   logic [63:0]   x2;
   logic [23:0]   lns_r;
   logic [MEAN_W-9:0]  sq24;
   logic [MEAN2_W-9:0] vdiff;
   logic          last_i;
   math_req_type  mreq;
   math_rsp_type  mrsp;

   gcl_math u_math (
      .clock(clock),
      .reset(reset),
      .req  (mreq),
      .rsp  (mrsp)
   );

   always_ff @(posedge clock) begin
      if (w_we) wmem[w_addr] <= req_ch.log_weight;
      w_rd_ff <= wmem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (p_we) pmem[i_ff] <= mrsp.result[32:0];
      p_rd_ff <= pmem[i_ff];
   end

   always_comb begin
      term   = 48'($signed({1'b0, i_ff}) * lf_ff) + 48'(w_rd_ff);
      diff   = 48'(m_ff - term);
      x2     = {4'b0, diff, 12'b0};
      lns_r  = 24'((lns_ff + 36'd2048) >> 12);
      sq24   = (MEAN_W-8)'((sq_ff + (2*(MEAN_W-8))'(1 << 23)) >> 24);
      vdiff  = n2_ff - (MEAN2_W-8)'(sq24);
      last_i = (i_ff == AW'(TABLE_DEPTH - 1));
      w_we   = 1'b0;
      w_addr = AW'(req_ch.count_index);
      p_we   = 1'b0;
      mreq   = '0;

      state_in   = state_ff;
      lf_in      = csr_wr_en ? csr_wr_data : lf_ff;
      valid_in   = valid_ff;
      i_in       = i_ff;
      any_in     = any_ff;
      m_in       = m_ff;
      highest_in = highest_ff;
      s_in       = s_ff;
      lns_in     = lns_ff;
      lxi_in     = lxi_ff;
      mean32_in  = mean32_ff;
      mean2_in   = mean2_ff;
      mean27_in  = mean27_ff;
      m24_in     = m24_ff;
      n2_in      = n2_ff;
      sq_in      = sq_ff;
      var_in     = var_ff;
      lo_in      = lo_ff;
      rv_in      = (rv_ff && rsp_ch.ready) ? 1'b0 : rv_ff;
      r_idx_in   = r_idx_ff;
      r_occ_in   = r_occ_ff;
      r_last_in  = r_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               case (req_ch.op)
                  OP_WRITE: begin
                     if (32'(req_ch.count_index) < TABLE_DEPTH) begin
                        w_we             = 1'b1;
                        valid_in[w_addr] = 1'b1;
                     end
                  end
                  OP_CLEAR: valid_in = '0;
                  OP_EVAL: begin
                     i_in       = '0;
                     any_in     = 1'b0;
                     m_in       = '0;
                     highest_in = 6'h3F;
                     s_in       = '0;
                     lxi_in     = '0;
                     mean32_in  = '0;
                     mean2_in   = '0;
                     state_in   = S_P1_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_P1_RD: state_in = S_P1_ACC;
         S_P1_ACC: begin
            if (valid_ff[i_ff]) begin
               if (!any_ff || term > m_ff) m_in = term;
               highest_in = 6'(i_ff);
               any_in     = 1'b1;
            end
            if (last_i) begin
               i_in     = '0;
               state_in = (any_ff || valid_ff[i_ff]) ? S_P2_RD : S_FIN1;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_P1_RD;
            end
         end
         S_P2_RD: state_in = S_P2_TERM;
         S_P2_TERM: begin
            if (valid_ff[i_ff]) begin
               mreq.start   = 1'b1;
               mreq.operand = x2;
               state_in     = S_P2_WAIT;
            end else if (last_i) begin
               state_in = S_LN_ST;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_P2_RD;
            end
         end
         S_P2_WAIT: begin
            if (mrsp.done) begin
               s_in = s_ff + SUM_W'(mrsp.result);
               if (last_i) begin
                  state_in = S_LN_ST;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_P2_RD;
               end
            end
         end
         S_LN_ST: begin
            mreq.start   = 1'b1;
            mreq.is_ln   = 1'b1;
            mreq.operand = 64'(s_ff);
            state_in     = S_LN_WAIT;
         end
         S_LN_WAIT: begin
            if (mrsp.done) begin
               lns_in   = mrsp.result;
               i_in     = '0;
               state_in = S_P3_RD;
            end
         end
         S_P3_RD: begin
            lxi_in   = 49'(m_ff) + $signed({25'b0, lns_r});
            state_in = S_P3_TERM;
         end
         S_P3_TERM: begin
            if (valid_ff[i_ff]) begin
               mreq.start   = 1'b1;
               mreq.operand = x2 + 64'(lns_ff);
               state_in     = S_P3_WAIT;
            end else if (last_i) begin
               state_in = S_FIN1;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_P3_RD;
            end
         end
         S_P3_WAIT: begin
            if (mrsp.done) begin
               p_we      = 1'b1;
               mean32_in = mean32_ff + MEAN_W'(i_ff * 38'(mrsp.result[32:0]));
               mean2_in  = mean2_ff + MEAN2_W'((2*AW)'(i_ff * i_ff)
                                                * MEAN2_W'(mrsp.result[32:0]));
               if (last_i) begin
                  state_in = S_FIN1;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_P3_RD;
               end
            end
         end
         S_FIN1: begin
            if (((mean32_ff + MEAN_W'(16)) >> 5) > MEAN_W'(32'hFFFF_FFFF))
               mean27_in = 32'hFFFF_FFFF;
            else
               mean27_in = 32'((mean32_ff + MEAN_W'(16)) >> 5);
            m24_in = (MEAN_W-8)'((mean32_ff + MEAN_W'(128)) >> 8);
            n2_in  = (MEAN2_W-8)'((mean2_ff + MEAN2_W'(128)) >> 8);
            if (lxi_ff > 49'sh7F_FFFF_FFFF)       lo_in = 40'sh7F_FFFF_FFFF;
            else if (lxi_ff < -49'sh80_0000_0000) lo_in = 40'sh80_0000_0000;
            else                                  lo_in = 40'(lxi_ff);
            state_in = S_FIN2;
         end
         S_FIN2: begin
            sq_in    = m24_ff * m24_ff;
            state_in = S_FIN3;
         end
         S_FIN3: begin
            if ((MEAN2_W-8)'(sq24) >= n2_ff)       var_in = '0;
            else if (vdiff > (MEAN2_W-8)'(32'hFFFF_FFFF)) var_in = 32'hFFFF_FFFF;
            else                                   var_in = 32'(vdiff);
            i_in     = '0;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: state_in = S_EMIT_LOAD;
         S_EMIT_LOAD: begin
            // load only when the output register is free or being drained
            if (!rv_ff || rsp_ch.ready) begin
               rv_in     = 1'b1;
               r_idx_in  = 5'(i_ff);
               r_occ_in  = !valid_ff[i_ff] ? 32'd0
                           : (p_rd_ff[32] ? 32'hFFFF_FFFF : p_rd_ff[31:0]);
               r_last_in = (i_ff == AW'(NEMIT - 1));
               if (i_ff == AW'(NEMIT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lf_ff    <= '0;
         valid_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lf_ff    <= lf_in;
         valid_ff <= valid_in;
         rv_ff    <= rv_in;
      end
      i_ff       <= i_in;
      any_ff     <= any_in;
      m_ff       <= m_in;
      highest_ff <= highest_in;
      s_ff       <= s_in;
      lns_ff     <= lns_in;
      lxi_ff     <= lxi_in;
      mean32_ff  <= mean32_in;
      mean2_ff   <= mean2_in;
      mean27_ff  <= mean27_in;
      m24_ff     <= m24_in;
      n2_ff      <= n2_in;
      sq_ff      <= sq_in;
      var_ff     <= var_in;
      lo_ff      <= lo_in;
      r_idx_ff   <= r_idx_in;
      r_occ_ff   <= r_occ_in;
      r_last_ff  <= r_last_in;
   end

   // the shared result fields stay put until the last result of a run has left
   assign req_ch.ready          = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_ch.valid          = rv_ff;
   assign rsp_ch.entry_index    = r_idx_ff;
   assign rsp_ch.occupancy      = r_occ_ff;
   assign rsp_ch.log_xi         = lo_ff;
   assign rsp_ch.mean_count     = mean27_ff;
   assign rsp_ch.count_variance = var_ff;
   assign rsp_ch.highest_valid  = highest_ff;
   assign rsp_ch.last           = r_last_ff;

   a_math_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> (state_ff == S_P2_WAIT || state_ff == S_LN_WAIT
                     || state_ff == S_P3_WAIT))
      else $error("math result outside a wait state");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last) |-> (rsp_ch.entry_index == 5'(NEMIT - 1)))
      else $error("last flag on wrong index");

   a_occ_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.occupancy != 32'd0) |-> !rsp_ch.highest_valid[5])
      else $error("nonzero occupancy with empty table");

endmodule

/* design/gcl_div.sv */
// restoring divider, one quotient bit per cycle
module gcl_div (
   input  logic               clock,
   input  logic               reset,
   input  gcl_pkg::div_req_type req,
   output gcl_pkg::div_rsp_type rsp
);
   import gcl_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [33:0] dvs_ff, dvs_in;
   logic [33:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [34:0] trial;
   logic [5:0]  bit_idx;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      bit_idx = 6'(cnt_ff - 7'd1);
      trial   = {rem_ff, dvd_ff[bit_idx]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.iters;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 34'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[33:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

/* design/gcl_math.sv */
// sequenced exp(-x) and ln(s) unit on a shared multiplier and divider
module gcl_math (
   input  logic                 clock,
   input  logic                 reset,
   input  gcl_pkg::math_req_type req,
   output gcl_pkg::math_rsp_type rsp
);
   import gcl_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE, E_RANGE, E_K, E_MUL, E_DIV, E_DWAIT, E_FIN,
      L_NORM, L_ZWAIT, L_MZ, L_Z2, L_MP, L_PDIV, L_PWAIT, L_FIN
   } mstate_type;

   mstate_type   state_ff, state_in;
   logic         done_ff, done_in;
   logic [35:0]  res_ff, res_in;
   logic [63:0]  x_ff, x_in;
   logic [36:0]  rem_ff, rem_in;
   logic [5:0]   k_ff, k_in;
   logic [2:0]   j_ff, j_in;
   logic [32:0]  term_ff, term_in;
   logic signed [35:0] sum_ff, sum_in;
   logic [4:0]   n_ff, n_in;
   logic [64:0]  prod_ff, prod_in;
   logic [31:0]  z_ff, z_in;
   logic [31:0]  z2_ff, z2_in;
   logic [31:0]  p_ff, p_in;
   logic [32:0]  acc_ff, acc_in;
   logic [2:0]   lk_ff, lk_in;
   logic [32:0]  mul_a;
   logic [31:0]  mul_b;
   logic [36:0]  step_val;
   logic [32:0]  clamped;
   logic [33:0]  rounded;
   logic [SUM_W-1:0] s_norm;
   logic [2:0]   lk;
   logic [32:0]  y;
   div_req_type  dreq;
   div_rsp_type  drsp;

   gcl_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (dreq),
      .rsp  (drsp)
   );

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      term_in  = term_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      z_in     = z_ff;
      z2_in    = z2_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      lk_in    = lk_ff;
      dreq     = '0;
      mul_a    = (state_ff == E_MUL) ? term_ff : ((state_ff == L_MZ) ? {1'b0, z_ff}
                                                                    : {1'b0, p_ff});
      mul_b    = (state_ff == E_MUL) ? rem_ff[31:0] : ((state_ff == L_MZ) ? z_ff : z2_ff);
      prod_in  = 65'(mul_a * mul_b);
      step_val = 37'(LN2_Q32) << j_ff;
      clamped  = sum_ff[35] ? 33'd0 : ((sum_ff > 36'sh1_0000_0000) ? 33'h1_0000_0000
                                                                    : sum_ff[32:0]);
      rounded  = ({1'b0, clamped} + (34'd1 << (k_ff - 6'd1))) >> k_ff;
      s_norm   = x_ff[SUM_W-1:0];
      if (s_norm < (SUM_W)'(64'h1_0000_0000)) s_norm = (SUM_W)'(64'h1_0000_0000);
      lk = 3'd0;
      for (int j = 0; j < LNK_STEPS; j++) begin
         if ((s_norm >> j) >= (SUM_W)'(64'h2_0000_0000)) lk = 3'(j + 1);
      end
      y = 33'(s_norm >> lk);

      case (state_ff)
         M_IDLE: begin
            if (req.start) begin
               x_in     = req.operand;
               state_in = req.is_ln ? L_NORM : E_RANGE;
            end
         end
         E_RANGE: begin
            if (x_ff >= 64'(EXP_LIMIT)) begin
               res_in   = '0;
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               rem_in   = x_ff[36:0];
               k_in     = '0;
               j_in     = 3'd5;
               state_in = E_K;
            end
         end
         E_K: begin
            if (rem_ff >= step_val) begin
               rem_in   = rem_ff - step_val;
               k_in[j_ff] = 1'b1;
            end
            if (j_ff == 3'd0) begin
               term_in  = 33'h1_0000_0000;
               sum_in   = 36'sh1_0000_0000;
               n_in     = 5'd1;
               state_in = E_MUL;
            end else begin
               j_in = j_ff - 3'd1;
            end
         end
         E_MUL: state_in = E_DIV;
         E_DIV: begin
            dreq.start    = 1'b1;
            dreq.dividend = 64'(prod_ff[64:32]);
            dreq.divisor  = 34'(n_ff);
            dreq.iters    = 7'd33;
            state_in      = E_DWAIT;
         end
         E_DWAIT: begin
            if (drsp.done) begin
               term_in = drsp.quotient[32:0];
               if (n_ff[0]) sum_in = sum_ff - $signed({3'b0, drsp.quotient[32:0]});
               else         sum_in = sum_ff + $signed({3'b0, drsp.quotient[32:0]});
               if (n_ff == EXP_TERMS) begin
                  state_in = E_FIN;
               end else begin
                  n_in     = n_ff + 5'd1;
                  state_in = E_MUL;
               end
            end
         end
         E_FIN: begin
            res_in   = (k_ff == 6'd0) ? 36'(clamped) : 36'(rounded);
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         L_NORM: begin
            lk_in         = lk;
            dreq.start    = 1'b1;
            dreq.dividend = {32'(y - 33'h1_0000_0000), 32'd0};
            dreq.divisor  = 34'(y) + 34'h1_0000_0000;
            dreq.iters    = 7'd64;
            state_in      = L_ZWAIT;
         end
         L_ZWAIT: begin
            if (drsp.done) begin
               z_in     = drsp.quotient[31:0];
               state_in = L_MZ;
            end
         end
         L_MZ: state_in = L_Z2;
         L_Z2: begin
            z2_in    = prod_ff[63:32];
            acc_in   = {1'b0, z_ff};
            p_in     = z_ff;
            n_in     = 5'd3;
            state_in = L_MP;
         end
         L_MP: state_in = L_PDIV;
         L_PDIV: begin
            p_in          = prod_ff[63:32];
            dreq.start    = 1'b1;
            dreq.dividend = 64'(prod_ff[63:32]);
            dreq.divisor  = 34'(n_ff);
            dreq.iters    = 7'd32;
            state_in      = L_PWAIT;
         end
         L_PWAIT: begin
            if (drsp.done) begin
               acc_in = acc_ff + {1'b0, drsp.quotient[31:0]};
               if (n_ff == LN_LAST) begin
                  state_in = L_FIN;
               end else begin
                  n_in     = n_ff + 5'd2;
                  state_in = L_MP;
               end
            end
         end
         L_FIN: begin
            res_in   = 36'(lk_ff * 36'(LN2_Q32)) + {2'b0, acc_ff, 1'b0};
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      res_ff  <= res_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      j_ff    <= j_in;
      term_ff <= term_in;
      sum_ff  <= sum_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      z_ff    <= z_in;
      z2_ff   <= z2_in;
      p_ff    <= p_in;
      acc_ff  <= acc_in;
      lk_ff   <= lk_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule
